### hw/rtl/cbc_pkg.sv
// Shared types and codes for the cartridge bank controller.
package cbc_pkg;

    // Region codes reported with every bus access.
    typedef enum logic [2:0] {
        REGION_FIXED_ROM  = 3'd0,
        REGION_BANKED_ROM = 3'd1,
        REGION_EXT_RAM    = 3'd2,
        REGION_OTHER      = 3'd3,
        REGION_BANK_WRITE = 3'd4,
        REGION_BLOCKED    = 3'd5
    } region_t;

    // Controller kinds held in the cart type register.
    localparam logic [1:0] CART_NONE = 2'd0;
    localparam logic [1:0] CART_MBC1 = 2'd1;
    localparam logic [1:0] CART_MBC2 = 2'd2;

    // Bank register areas, selected by address bits 14:13 below 0x8000.
    localparam logic [1:0] AREA_RAM_ENABLE = 2'd0;
    localparam logic [1:0] AREA_ROM_LOW    = 2'd1;
    localparam logic [1:0] AREA_BANK_HIGH  = 2'd2;
    localparam logic [1:0] AREA_MODE       = 2'd3;

    // Access kinds.
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Reset values of the banking state.
    localparam logic [6:0] ROM_BANK_RESET  = 7'd1;
    localparam logic [1:0] CART_TYPE_RESET = CART_MBC1;

    // Value of the low data nibble that enables external RAM.
    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

endpackage

### hw/rtl/cartridge_bank_controller.sv
// Cartridge bank controller: bus access decode, address translation and bank registers.
//
// The controller translates one bus access per clock cycle while the receiver takes
// each result. An access transfer is taken whenever the result register is empty or
// its result is being taken in the same cycle, so a steady stream runs at one access
// per cycle into the result register. All decoding, translation and the
// bank register update are done in a single pass between the input port and the
// result register; the bank registers are updated at the access transfer, so the
// next access already sees the new banks. The cart type register is written through
// its own port, which is always ready, and should only be changed while no result
// is pending. Reset selects MBC1 style, ROM bank 1, RAM bank 0, ROM banking mode
// and external RAM disabled.
module cartridge_bank_controller
    import cbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [15:0] address,
    input  logic [7:0]  wdata,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  region,
    output logic [20:0] mapped_address,
    output logic        write_allowed
);

    // Configuration and banking state.
    logic [1:0]  cart_type_reg;
    logic [6:0]  rom_bank_reg, rom_bank_next;
    logic [1:0]  ram_bank_reg, ram_bank_next;
    logic        banking_mode_reg, banking_mode_next;
    logic        ram_enabled_reg, ram_enabled_next;

    // Result register.
    logic        out_valid_reg;
    region_t     region_reg, region_next;
    logic [20:0] mapped_reg, mapped_next;
    logic        allowed_reg, allowed_next;

    logic        in_xfer;
    logic        is_write;
    logic        is_rom_area;
    logic        is_ram_area;
    logic        is_banned;
    logic        has_mbc;
    logic        is_mbc2;
    logic [3:0]  low4;
    logic [4:0]  low5;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_xfer   = in_valid && in_ready;

    assign is_write    = (kind == KIND_WRITE);
    assign is_rom_area = !address[15];
    assign is_ram_area = (address[15:13] == 3'b101);
    assign is_banned   = ((address >= 16'hFEA0) && (address < 16'hFF00)) ||
                         ((address >= 16'hFF4C) && (address < 16'hFF80));
    assign has_mbc     = (cart_type_reg == CART_MBC1) || (cart_type_reg == CART_MBC2);
    assign is_mbc2     = (cart_type_reg == CART_MBC2);

    // Bank numbers written with zero select bank one.
    assign low4 = (wdata[3:0] == 4'd0) ? 4'd1 : wdata[3:0];
    assign low5 = (wdata[4:0] == 5'd0) ? 5'd1 : wdata[4:0];

    // Region decode and address translation with the banks before this access.
    always_comb
    begin
        region_next  = REGION_OTHER;
        mapped_next  = {5'd0, address};
        allowed_next = 1'b0;
        if (is_rom_area && !is_write)
        begin
            if (!address[14])
            begin
                region_next = REGION_FIXED_ROM;
            end
            else
            begin
                region_next = REGION_BANKED_ROM;
                mapped_next = {rom_bank_reg, address[13:0]};
            end
        end
        else if (is_rom_area)
        begin
            region_next = REGION_BANK_WRITE;
        end
        else if (is_ram_area)
        begin
            mapped_next = {6'd0, ram_bank_reg, address[12:0]};
            if (!is_write)
            begin
                region_next = REGION_EXT_RAM;
            end
            else if (ram_enabled_reg)
            begin
                region_next  = REGION_EXT_RAM;
                allowed_next = 1'b1;
            end
            else
            begin
                region_next = REGION_BLOCKED;
            end
        end
        else
        begin
            allowed_next = is_write && !is_banned;
        end
    end

    // Bank register update for writes below 0x8000.
    always_comb
    begin
        rom_bank_next     = rom_bank_reg;
        ram_bank_next     = ram_bank_reg;
        banking_mode_next = banking_mode_reg;
        ram_enabled_next  = ram_enabled_reg;
        if (in_xfer && is_write && is_rom_area && has_mbc)
        begin
            unique case (address[14:13])
                AREA_RAM_ENABLE:
                begin
                    if (!(is_mbc2 && address[8]))
                    begin
                        ram_enabled_next = (wdata[3:0] == RAM_ENABLE_KEY);
                    end
                end
                AREA_ROM_LOW:
                begin
                    if (is_mbc2)
                    begin
                        if (address[8])
                        begin
                            rom_bank_next = {3'd0, low4};
                        end
                    end
                    else
                    begin
                        rom_bank_next = {rom_bank_reg[6:5], low5};
                    end
                end
                AREA_BANK_HIGH:
                begin
                    if (banking_mode_reg)
                    begin
                        ram_bank_next = wdata[1:0];
                    end
                    else
                    begin
                        ram_bank_next = 2'd0;
                        rom_bank_next = {wdata[1:0], rom_bank_reg[4:0]};
                    end
                end
                AREA_MODE:
                begin
                    banking_mode_next = wdata[0];
                end
                default:
                begin
                    banking_mode_next = banking_mode_reg;
                end
            endcase
        end
    end

    // Control and banking state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cart_type_reg    <= CART_TYPE_RESET;
            rom_bank_reg     <= ROM_BANK_RESET;
            ram_bank_reg     <= 2'd0;
            banking_mode_reg <= 1'b0;
            ram_enabled_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cart_type_reg <= cfg_data;
            end
            rom_bank_reg     <= rom_bank_next;
            ram_bank_reg     <= ram_bank_next;
            banking_mode_reg <= banking_mode_next;
            ram_enabled_reg  <= ram_enabled_next;
            if (in_xfer)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, loaded on each access transfer.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            region_reg  <= region_next;
            mapped_reg  <= mapped_next;
            allowed_reg <= allowed_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign region         = region_reg;
    assign mapped_address = mapped_reg;
    assign write_allowed  = allowed_reg;

    // The low five bits of the ROM bank never read as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        rom_bank_reg[4:0] != 5'd0)
        else $error("ROM bank low bits are zero");

    // A banked ROM result never points into bank zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (region_reg == REGION_BANKED_ROM) |-> mapped_reg[20:14] != 7'd0)
        else $error("banked ROM result maps to bank zero");

    // A read transfer never yields a permitted write.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && !is_write |=> !allowed_reg)
        else $error("read transfer marked as an allowed write");

    // Permitted writes only target external RAM or other memory.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && allowed_reg |->
            (region_reg == REGION_EXT_RAM) || (region_reg == REGION_OTHER))
        else $error("allowed write in a region that takes no writes");

    // A pending result is held until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(mapped_reg))
        else $error("pending result lost or changed");

endmodule

### tb/tb_cartridge_bank_controller.sv
// Self-checking testbench for the cartridge bank controller with bursty traffic and output stalls.
module tb_cartridge_bank_controller
    import cbc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Memory map boundaries used by the translation predictor.
    localparam logic [15:0] ROM_BANKED_BASE = 16'h4000;
    localparam logic [15:0] VIDEO_BASE      = 16'h8000;
    localparam logic [15:0] EXT_RAM_BASE    = 16'hA000;
    localparam logic [15:0] WORK_RAM_BASE   = 16'hC000;
    localparam logic [15:0] UNUSABLE_BASE   = 16'hFEA0;
    localparam logic [15:0] IO_BASE         = 16'hFF00;
    localparam logic [15:0] IO_HOLE_BASE    = 16'hFF4C;
    localparam logic [15:0] HIGH_RAM_BASE   = 16'hFF80;

    // Cart type code that no controller uses; it must act like no controller.
    localparam logic [1:0] CART_UNUSED = 2'd3;

    // Cart type per phase, phase 0 in the low bits (phase 0 keeps the reset value).
    localparam int          NUM_PHASES  = 7;
    localparam logic [13:0] PHASE_CARTS = {CART_MBC1, CART_MBC2, CART_MBC1, CART_UNUSED,
                                           CART_NONE, CART_MBC2, CART_MBC1};
    localparam int          RANDOM_PER_PHASE = 205;
    localparam int          DRAIN_CYCLES     = 4;
    localparam int          CYCLE_LIMIT      = 400000;

    // Receiver stall patterns.
    localparam int RX_ALWAYS   = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_PERIODIC = 2;
    localparam int RX_SPARSE   = 3;

    typedef struct packed {
        logic        kind;
        logic [15:0] address;
        logic [7:0]  wdata;
    } bus_access_t;

    typedef struct packed {
        region_t     region;
        logic [20:0] mapped;
        logic        allowed;
    } translation_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data = CART_MBC1;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        kind = KIND_READ;
    logic [15:0] address = 16'h0000;
    logic [7:0]  wdata = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  region;
    logic [20:0] mapped_address;
    logic        write_allowed;

    // Predictor copy of the banking state and the cart type.
    logic [1:0] cart_cfg = CART_TYPE_RESET;
    logic [6:0] rom_bank_q = ROM_BANK_RESET;
    logic [1:0] ram_bank_q = 2'd0;
    logic       ram_mode_q = 1'b0;
    logic       ram_on_q = 1'b0;

    bus_access_t  pending_accesses[$];
    translation_t expected_translations[$];
    int           accesses_queued = 0;
    int           results_checked = 0;
    int           error_count = 0;
    int           cycle_count = 0;

    cartridge_bank_controller uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .address        (address),
        .wdata          (wdata),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .region         (region),
        .mapped_address (mapped_address),
        .write_allowed  (write_allowed)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Translate one access and apply any bank register update it carries.
    function automatic translation_t translate_access(input bus_access_t acc);
        translation_t res;
        logic         mbc2;
        logic         sel8;
        logic [4:0]   low5;
        res.region  = REGION_OTHER;
        res.mapped  = {5'd0, acc.address};
        res.allowed = 1'b0;
        mbc2 = (cart_cfg == CART_MBC2);
        sel8 = acc.address[8];
        if (acc.address < ROM_BANKED_BASE && acc.kind == KIND_READ)
        begin
            res.region = REGION_FIXED_ROM;
        end
        else if (acc.address < VIDEO_BASE && acc.kind == KIND_READ)
        begin
            res.region = REGION_BANKED_ROM;
            res.mapped = {rom_bank_q, acc.address[13:0]};
        end
        else if (acc.address < VIDEO_BASE)
        begin
            res.region = REGION_BANK_WRITE;
            if (cart_cfg == CART_MBC1 || mbc2)
            begin
                case (acc.address[14:13])
                    AREA_RAM_ENABLE:
                    begin
                        // MBC2 only decodes the enable when address bit 8 is clear.
                        if (!(mbc2 && sel8))
                            ram_on_q = (acc.wdata[3:0] == RAM_ENABLE_KEY);
                    end
                    AREA_ROM_LOW:
                    begin
                        // Bank zero in the low field is always promoted to one.
                        if (mbc2)
                        begin
                            if (sel8)
                            begin
                                low5 = {1'b0, acc.wdata[3:0]};
                                if (low5 == 5'd0)
                                    low5 = 5'd1;
                                rom_bank_q = {2'b00, low5};
                            end
                        end
                        else
                        begin
                            low5 = acc.wdata[4:0];
                            if (low5 == 5'd0)
                                low5 = 5'd1;
                            rom_bank_q = {rom_bank_q[6:5], low5};
                        end
                    end
                    AREA_BANK_HIGH:
                    begin
                        if (ram_mode_q)
                        begin
                            ram_bank_q = acc.wdata[1:0];
                        end
                        else
                        begin
                            ram_bank_q = 2'd0;
                            rom_bank_q = {acc.wdata[1:0], rom_bank_q[4:0]};
                        end
                    end
                    AREA_MODE:
                    begin
                        ram_mode_q = acc.wdata[0];
                    end
                endcase
            end
        end
        else if (acc.address >= EXT_RAM_BASE && acc.address < WORK_RAM_BASE)
        begin
            res.mapped = {6'd0, ram_bank_q, acc.address[12:0]};
            if (acc.kind == KIND_READ)
            begin
                res.region = REGION_EXT_RAM;
            end
            else if (ram_on_q)
            begin
                res.region  = REGION_EXT_RAM;
                res.allowed = 1'b1;
            end
            else
            begin
                res.region = REGION_BLOCKED;
            end
        end
        else if (acc.kind == KIND_WRITE)
        begin
            // The unusable area and the I/O hole never take writes.
            res.allowed = !((acc.address >= UNUSABLE_BASE && acc.address < IO_BASE) ||
                            (acc.address >= IO_HOLE_BASE && acc.address < HIGH_RAM_BASE));
        end
        return res;
    endfunction

    // Random access, weighted toward bank register writes and the RAM window.
    function automatic bus_access_t random_access();
        bus_access_t acc;
        int unsigned pick;
        pick        = $urandom_range(0, 99);
        acc.kind    = 1'($urandom_range(0, 1));
        acc.address = 16'($urandom_range(0, 16'hFFFF));
        acc.wdata   = 8'($urandom_range(0, 255));
        if (pick < 30)
        begin
            acc.kind        = KIND_WRITE;
            acc.address[15] = 1'b0;
            if ($urandom_range(0, 1) == 0)
                acc.wdata[3:0] = RAM_ENABLE_KEY;
        end
        else if (pick < 50)
        begin
            acc.kind        = KIND_READ;
            acc.address[15] = 1'b0;
        end
        else if (pick < 75)
        begin
            acc.address[15:13] = 3'b101;
        end
        else if (pick < 90)
        begin
            acc.kind    = KIND_WRITE;
            acc.address = 16'($urandom_range(16'hFE80, 16'hFFFF));
        end
        return acc;
    endfunction

    task automatic queue_access(input logic k, input logic [15:0] a, input logic [7:0] d);
        bus_access_t acc;
        acc.kind    = k;
        acc.address = a;
        acc.wdata   = d;
        pending_accesses.push_back(acc);
        accesses_queued++;
    endtask

    task automatic report_mismatch(input string msg);
        if (error_count < 50)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Hold off until every queued access has produced its checked result.
    task automatic wait_for_drain();
        while (results_checked != accesses_queued)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cart_type(input logic [1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cart_cfg = value;
    endtask

    // Access driver: bursts of random length separated by random gaps.
    always @(posedge clk)
    begin : access_driver
        bus_access_t cur_access;
        int          burst_left;
        int          gap_left;
        logic        next_valid;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_translations.push_back(translate_access(cur_access));
            if (!in_valid || in_ready)
            begin
                next_valid = 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_accesses.size() != 0)
                begin
                    cur_access = pending_accesses.pop_front();
                    next_valid = 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                in_valid <= next_valid;
                if (next_valid)
                begin
                    kind    <= cur_access.kind;
                    address <= cur_access.address;
                    wdata   <= cur_access.wdata;
                end
            end
        end
    end

    // Result checker with its own stall pattern on out_ready.
    always @(posedge clk)
    begin : result_checker
        translation_t want;
        int           rx_tick;
        int           rx_mode;
        logic         next_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_translations.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result region=%0d addr=%h",
                                              region, mapped_address));
                end
                else
                begin
                    want = expected_translations.pop_front();
                    results_checked++;
                    if (region !== want.region)
                        report_mismatch($sformatf("region got %0d want %0d",
                                                  region, want.region));
                    if (mapped_address !== want.mapped)
                        report_mismatch($sformatf("mapped_address got %h want %h",
                                                  mapped_address, want.mapped));
                    if (write_allowed !== want.allowed)
                        report_mismatch($sformatf("write_allowed got %b want %b",
                                                  write_allowed, want.allowed));
                end
            end
            rx_tick++;
            if (rx_tick % 97 == 0)
                rx_mode = $urandom_range(RX_ALWAYS, RX_SPARSE);
            case (rx_mode)
                RX_RANDOM:   next_ready = 1'($urandom_range(0, 1));
                RX_PERIODIC: next_ready = (rx_tick % 4 != 0);
                RX_SPARSE:   next_ready = ($urandom_range(0, 7) == 0);
                default:     next_ready = 1'b1;
            endcase
            out_ready <= next_ready;
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Phase sequencer: reset, then cart type changes only while the controller is idle.
    initial
    begin
        logic [1:0]  phase_cart;
        logic        mbc2_directed_done;
        bus_access_t rnd;
        mbc2_directed_done = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            phase_cart = PHASE_CARTS[2 * p +: 2];
            if (p != 0)
            begin
                wait_for_drain();
                write_cart_type(phase_cart);
            end
            if (p == 0)
            begin
                // Map corners in the reset state.
                queue_access(KIND_READ, 16'h0000, 8'h00);
                queue_access(KIND_READ, 16'h3FFF, 8'hFF);
                queue_access(KIND_READ, 16'h4000, 8'h00);
                queue_access(KIND_READ, 16'h7FFF, 8'h00);
                // RAM disabled after reset, then enabled and disabled again.
                queue_access(KIND_WRITE, 16'hA000, 8'h55);
                queue_access(KIND_READ, 16'hBFFF, 8'h00);
                queue_access(KIND_WRITE, 16'h0000, 8'h0A);
                queue_access(KIND_WRITE, 16'hA000, 8'hFF);
                queue_access(KIND_WRITE, 16'h1FFF, 8'h00);
                queue_access(KIND_WRITE, 16'hBFFF, 8'h00);
                // Low bank zero becomes one; then the largest bank.
                queue_access(KIND_WRITE, 16'h2000, 8'h00);
                queue_access(KIND_WRITE, 16'h3FFF, 8'hFF);
                queue_access(KIND_WRITE, 16'h4000, 8'h03);
                queue_access(KIND_READ, 16'h7FFF, 8'h00);
                // RAM banking mode selects the RAM bank; going back to ROM mode keeps it.
                queue_access(KIND_WRITE, 16'h6000, 8'h01);
                queue_access(KIND_WRITE, 16'h5FFF, 8'hFF);
                queue_access(KIND_WRITE, 16'h7FFF, 8'hFE);
                queue_access(KIND_READ, 16'hBFFF, 8'h00);
                // Prohibited areas and their neighbors.
                queue_access(KIND_WRITE, 16'hFEA0, 8'h11);
                queue_access(KIND_WRITE, 16'hFEFF, 8'h22);
                queue_access(KIND_WRITE, 16'hFF4C, 8'h33);
                queue_access(KIND_WRITE, 16'hFF7F, 8'h44);
                queue_access(KIND_WRITE, 16'hFE9F, 8'h55);
                queue_access(KIND_WRITE, 16'hFF80, 8'h66);
                queue_access(KIND_WRITE, 16'h8000, 8'h77);
                queue_access(KIND_READ, 16'hFFFF, 8'h00);
            end
            if (phase_cart == CART_MBC2 && !mbc2_directed_done)
            begin
                // MBC2 address bit 8 selects between RAM enable and ROM bank.
                queue_access(KIND_WRITE, 16'h0100, 8'h0A);
                queue_access(KIND_WRITE, 16'h0000, 8'h0A);
                queue_access(KIND_WRITE, 16'h2000, 8'h05);
                queue_access(KIND_WRITE, 16'h2100, 8'h00);
                queue_access(KIND_WRITE, 16'h21FF, 8'hF7);
                queue_access(KIND_READ, 16'h4000, 8'h00);
                mbc2_directed_done = 1'b1;
            end
            repeat (RANDOM_PER_PHASE)
            begin
                rnd = random_access();
                queue_access(rnd.kind, rnd.address, rnd.wdata);
            end
        end
        wait_for_drain();
        if (expected_translations.size() != 0)
            report_mismatch($sformatf("%0d results never arrived",
                                      expected_translations.size()));
        if (error_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/cbc_pkg.sv
hw/rtl/cartridge_bank_controller.sv
tb/tb_cartridge_bank_controller.sv
